FILE: sv/mkd_pkg.sv
package mkd_pkg;

   localparam int MAX_SYMBOLS   = 8;
   localparam int TABLE_LETTERS = 26;

   localparam int DUR_W   = 16;
   localparam int SYM_W   = 8;
   localparam int PCNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int LCNT_W  = 4;
   localparam int LTR_W   = 5;
   localparam int KIND_W  = 3;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;

   typedef logic [DUR_W-1:0]   dur_type;
   typedef logic [SYM_W-1:0]   sym_type;
   typedef logic [PCNT_W-1:0]  pcnt_type;
   typedef logic [LCNT_W-1:0]  lcnt_type;
   typedef logic [LTR_W-1:0]   ltr_type;
   typedef logic [CSR_A_W-1:0] csr_addr_type;
   typedef logic [CSR_D_W-1:0] csr_data_type;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE    = 3'd0,
      EV_DOT     = 3'd1,
      EV_DASH    = 3'd2,
      EV_INVALID = 3'd3,
      EV_LETTER  = 3'd4,
      EV_NOMATCH = 3'd5
   } event_kind_type;

   localparam logic OP_PRESS = 1'b0;
   localparam logic OP_GAP   = 1'b1;

   localparam csr_addr_type CSR_LETTER_GAP  = 2'd0;
   localparam csr_addr_type CSR_DOT_DASH    = 2'd1;
   localparam csr_addr_type CSR_MAX_PRESS   = 2'd2;
   localparam csr_addr_type CSR_MSG_LETTERS = 2'd3;

   localparam dur_type  RST_LETTER_GAP  = 16'd200;
   localparam dur_type  RST_DOT_DASH    = 16'd100;
   localparam dur_type  RST_MAX_PRESS   = 16'd700;
   localparam lcnt_type RST_MSG_LETTERS = 4'd4;

   // code bits (symbol i at bit i, dash = 1), A..Z
   localparam sym_type MORSE_BITS [TABLE_LETTERS] = '{
      8'd2, 8'd1, 8'd5, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14, 8'd5, 8'd2, 8'd3,
      8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1, 8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3
   };
   // symbol counts, A..Z
   localparam logic [2:0] MORSE_LEN [TABLE_LETTERS] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

endpackage

FILE: sv/mkd_if.sv
interface mkd_req_if;
   import mkd_pkg::*;
   logic    valid;
   logic    ready;
   logic    operation;
   dur_type duration_ms;
   modport source (output valid, output operation, output duration_ms, input ready);
   modport sink (input valid, input operation, input duration_ms, output ready);
endinterface

interface mkd_rsp_if;
   import mkd_pkg::*;
   logic     valid;
   logic     ready;
   logic [KIND_W-1:0] event_kind;
   ltr_type  letter_index;
   lcnt_type letters_so_far;
   logic     message_done;
   modport source (output valid, output event_kind, output letter_index,
                   output letters_so_far, output message_done, input ready);
   modport sink (input valid, input event_kind, input letter_index,
                 input letters_so_far, input message_done, output ready);
endinterface

interface mkd_csr_if;
   import mkd_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/mkd_match.sv
module mkd_match (
   input  mkd_pkg::sym_type  symbols,
   input  mkd_pkg::pcnt_type count,
   output logic              hit,
   output mkd_pkg::ltr_type  index
);
   import mkd_pkg::*;

   // codes are unique, so scanning down leaves the single match
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int i = TABLE_LETTERS - 1; i >= 0; i--) begin
         if (count == PCNT_W'(MORSE_LEN[i]) && symbols == MORSE_BITS[i]) begin
            hit   = 1'b1;
            index = LTR_W'(i);
         end
      end
   end
endmodule

FILE: sv/morse_key_decoder_top.sv
// Channel    Port       Dir   Fields
// --------   --------   ---   ------------------------------------------------
// request    req_item   in    operation, duration_ms
// response   rsp_item   out   event_kind, letter_index, letters_so_far, message_done
// register   csr_wr     in    index (0..3), data
//
// One response per request item, registered in the result register.
// A new item is taken every cycle while the result register is empty or being drained.
// The pattern match is a single pass over the 26-entry constant code table.
// Synchronous active-high reset: registers go to 200/100/700/4, decoder state clears.
// A stalled response holds; the request side stalls only while the result is stuck.
module morse_key_decoder_top (
   input logic     clock,
   input logic     reset,
   mkd_req_if.sink   req_item,
   mkd_rsp_if.source rsp_item,
   mkd_csr_if.sink   csr_wr
);
   import mkd_pkg::*;

   // configuration
   dur_type  letter_gap_ff, letter_gap_in;
   dur_type  dot_dash_ff, dot_dash_in;
   dur_type  max_press_ff, max_press_in;
   lcnt_type msg_letters_ff, msg_letters_in;

   // decoder state
   sym_type  sym_ff, sym_in;
   pcnt_type pcnt_ff, pcnt_in;
   lcnt_type lcnt_ff, lcnt_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   event_kind_type kind_ff, kind_in;
   ltr_type        letter_ff, letter_in;
   lcnt_type       so_far_ff, so_far_in;
   logic           done_ff, done_in;

   logic     req_fire;
   logic     is_dash;
   logic     match_hit;
   ltr_type  match_idx;
   lcnt_type lcnt_inc;

   assign csr_wr.ready   = 1'b1;
   assign req_item.ready = !rsp_valid_ff || rsp_item.ready;
   assign req_fire       = req_item.valid && req_item.ready;

   assign rsp_item.valid          = rsp_valid_ff;
   assign rsp_item.event_kind     = kind_ff;
   assign rsp_item.letter_index   = letter_ff;
   assign rsp_item.letters_so_far = so_far_ff;
   assign rsp_item.message_done   = done_ff;

   mkd_match u_match (
      .symbols (sym_ff),
      .count   (pcnt_ff),
      .hit     (match_hit),
      .index   (match_idx)
   );

   // register writes
   always_comb begin
      letter_gap_in  = letter_gap_ff;
      dot_dash_in    = dot_dash_ff;
      max_press_in   = max_press_ff;
      msg_letters_in = msg_letters_ff;
      if (csr_wr.valid) begin
         case (csr_wr.index)
            CSR_LETTER_GAP:  letter_gap_in  = csr_wr.data;
            CSR_DOT_DASH:    dot_dash_in    = csr_wr.data;
            CSR_MAX_PRESS:   max_press_in   = csr_wr.data;
            CSR_MSG_LETTERS: msg_letters_in = csr_wr.data[LCNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign is_dash  = !(req_item.duration_ms < dot_dash_ff);
   assign lcnt_inc = lcnt_ff + LCNT_W'(1);

   // one item: classify, update pattern/count, build the result
   always_comb begin
      sym_in    = sym_ff;
      pcnt_in   = pcnt_ff;
      lcnt_in   = lcnt_ff;
      kind_in   = EV_NONE;
      letter_in = '0;
      so_far_in = lcnt_ff;
      done_in   = 1'b0;
      if (req_fire) begin
         if (req_item.operation == OP_PRESS) begin
            if (req_item.duration_ms > max_press_ff) begin
               kind_in = EV_INVALID;
            end else begin
               kind_in = is_dash ? EV_DASH : EV_DOT;
               // only the first SYM_W symbols are kept
               if (32'(pcnt_ff) < 32'(SYM_W) && is_dash) begin
                  sym_in = sym_ff | (SYM_W'(1) << pcnt_ff);
               end
               if (32'(pcnt_ff) < 32'(MAX_SYMBOLS)) begin
                  pcnt_in = pcnt_ff + PCNT_W'(1);
               end
            end
         end else if (pcnt_ff != '0 && req_item.duration_ms > letter_gap_ff) begin
            sym_in  = '0;
            pcnt_in = '0;
            if (match_hit) begin
               kind_in   = EV_LETTER;
               letter_in = match_idx;
               so_far_in = lcnt_inc;
               // a message length of zero completes on every letter
               if (lcnt_inc >= msg_letters_ff) begin
                  done_in = 1'b1;
                  lcnt_in = '0;
               end else begin
                  lcnt_in = lcnt_inc;
               end
            end else begin
               kind_in = EV_NOMATCH;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_item.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_gap_ff  <= RST_LETTER_GAP;
         dot_dash_ff    <= RST_DOT_DASH;
         max_press_ff   <= RST_MAX_PRESS;
         msg_letters_ff <= RST_MSG_LETTERS;
         sym_ff         <= '0;
         pcnt_ff        <= '0;
         lcnt_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         letter_gap_ff  <= letter_gap_in;
         dot_dash_ff    <= dot_dash_in;
         max_press_ff   <= max_press_in;
         msg_letters_ff <= msg_letters_in;
         sym_ff         <= sym_in;
         pcnt_ff        <= pcnt_in;
         lcnt_ff        <= lcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload loads only with a new item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff   <= kind_in;
         letter_ff <= letter_in;
         so_far_ff <= so_far_in;
         done_ff   <= done_in;
      end
   end

   // pending count saturates at the symbol limit
   a_pcnt_sat: assert property (@(posedge clock) disable iff (reset)
      32'(pcnt_ff) <= 32'(MAX_SYMBOLS))
      else $error("pending count beyond limit");

   // a letter-ending gap empties the pattern
   a_gap_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.operation == OP_GAP && pcnt_ff != '0
         && req_item.duration_ms > letter_gap_ff |=> pcnt_ff == '0 && sym_ff == '0)
      else $error("pattern not cleared after letter gap");

   // message completion only comes with a decoded letter
   a_done_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> kind_ff == EV_LETTER)
      else $error("message done without a letter");

   // a completed message restarts the count
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && done_in |=> lcnt_ff == '0)
      else $error("letter count not cleared on message done");

   // letter index is zero unless a letter was decoded
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != EV_LETTER |-> letter_ff == '0)
      else $error("stray letter index");
endmodule
